[rtl/core/msd_pkg.sv]
package msd_pkg;

	localparam int unsigned TREE_DEPTH = 128;
	localparam int unsigned NODE_W     = $clog2(TREE_DEPTH);
	localparam int unsigned CHAR_W     = 8;

	// last node that still has children in the depth-six tree
	localparam logic [NODE_W-1:0] LAST_INNER = NODE_W'(62);
	localparam logic [NODE_W-1:0] ROOT_NODE  = '0;

	localparam logic [CHAR_W-1:0] CH_FILLER = 8'h23;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NONE   = 8'h00;

	// stage 1 control, walker to emitter
	typedef struct packed {
		logic valid;
		logic boundary;
		logic invalid;
		logic word_space;
	} lane_s1_t;

	// heap-indexed Morse tree, zero marks a missing node
	function automatic logic [CHAR_W-1:0] code_char(input logic [NODE_W-1:0] idx);
		logic [CHAR_W-1:0] c;
		unique case (idx)
			7'd0:   c = CH_FILLER;
			7'd1:   c = "E";
			7'd2:   c = "T";
			7'd3:   c = "I";
			7'd4:   c = "A";
			7'd5:   c = "N";
			7'd6:   c = "M";
			7'd7:   c = "S";
			7'd8:   c = "U";
			7'd9:   c = "R";
			7'd10:  c = "W";
			7'd11:  c = "D";
			7'd12:  c = "K";
			7'd13:  c = "G";
			7'd14:  c = "O";
			7'd15:  c = "H";
			7'd16:  c = "V";
			7'd17:  c = "F";
			7'd18:  c = CH_FILLER;
			7'd19:  c = "L";
			7'd20:  c = CH_FILLER;
			7'd21:  c = "P";
			7'd22:  c = "J";
			7'd23:  c = "B";
			7'd24:  c = "X";
			7'd25:  c = "C";
			7'd26:  c = "Y";
			7'd27:  c = "Z";
			7'd28:  c = "Q";
			7'd29:  c = CH_FILLER;
			7'd30:  c = CH_FILLER;
			7'd31:  c = "5";
			7'd32:  c = "4";
			7'd34:  c = "3";
			7'd37:  c = CH_FILLER;
			7'd38:  c = "2";
			7'd39:  c = "&";
			7'd40:  c = CH_FILLER;
			7'd41:  c = "+";
			7'd44:  c = CH_FILLER;
			7'd46:  c = "1";
			7'd47:  c = "6";
			7'd48:  c = "=";
			7'd49:  c = "/";
			7'd52:  c = CH_FILLER;
			7'd53:  c = "(";
			7'd55:  c = "7";
			7'd56:  c = CH_FILLER;
			7'd58:  c = 8'd165;
			7'd59:  c = "8";
			7'd61:  c = "9";
			7'd62:  c = "0";
			7'd75:  c = "?";
			7'd76:  c = "_";
			7'd81:  c = 8'h22;
			7'd84:  c = ".";
			7'd89:  c = "@";
			7'd93:  c = 8'd39;
			7'd96:  c = "-";
			7'd105: c = ";";
			7'd106: c = "!";
			7'd108: c = ")";
			7'd114: c = ",";
			7'd119: c = ":";
			default: c = CH_NONE;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/msd_ram.sv]
module msd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/msd_walker.sv]
module msd_walker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [msd_pkg::CHAR_W-1:0]    symbol,
	input  logic                          last,
	input  logic                          advance,
	output msd_pkg::lane_s1_t             lane_s1,
	output logic                          ram_we,
	output logic [msd_pkg::NODE_W-1:0]    ram_waddr,
	output logic [msd_pkg::CHAR_W-1:0]    ram_wdata,
	output logic                          ram_re,
	output logic [msd_pkg::NODE_W-1:0]    ram_raddr
);

	localparam int unsigned FILL_W = msd_pkg::NODE_W + 1;

	logic [FILL_W-1:0]          fill_q;
	logic                       fill_done;
	logic [msd_pkg::NODE_W-1:0] node_q, node_nx, child;
	logic                       inv_q, inv_nx, prev_q;
	logic                       is_dot, is_dash, is_space, boundary, accept;

	assign fill_done = fill_q[FILL_W-1];

	// table load sweep after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (!fill_done) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	assign ram_we    = !fill_done;
	assign ram_waddr = fill_q[msd_pkg::NODE_W-1:0];
	assign ram_wdata = msd_pkg::code_char(fill_q[msd_pkg::NODE_W-1:0]);

	assign in_ready = fill_done && (!lane_s1.valid || advance);
	assign accept   = in_valid && in_ready;

	assign is_dot   = (symbol == msd_pkg::CH_DOT);
	assign is_dash  = (symbol == msd_pkg::CH_DASH);
	assign is_space = (symbol == msd_pkg::CH_SPACE);
	assign boundary = is_space || last;

	// children at 2n+1 (dot) and 2n+2 (dash)
	assign child = {node_q[msd_pkg::NODE_W-2:0], 1'b0}
		+ {{(msd_pkg::NODE_W-2){1'b0}}, is_dash, !is_dash};

	always_comb begin
		node_nx = node_q;
		inv_nx  = inv_q;
		if ((is_dot || is_dash) && !inv_q) begin
			if (node_q > msd_pkg::LAST_INNER) begin
				inv_nx = 1'b1;
			end else if (msd_pkg::code_char(child) == msd_pkg::CH_NONE) begin
				inv_nx = 1'b1;
			end else begin
				node_nx = child;
			end
		end
	end

	assign ram_re    = accept;
	assign ram_raddr = node_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= msd_pkg::ROOT_NODE;
			inv_q  <= 1'b0;
			prev_q <= 1'b0;
		end else if (accept) begin
			node_q <= boundary ? msd_pkg::ROOT_NODE : node_nx;
			inv_q  <= boundary ? 1'b0 : inv_nx;
			prev_q <= is_space && !last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_s1 <= '0;
		end else if (accept) begin
			lane_s1.valid      <= 1'b1;
			lane_s1.boundary   <= boundary;
			lane_s1.invalid    <= inv_nx;
			lane_s1.word_space <= is_space && prev_q;
		end else if (advance) begin
			lane_s1.valid <= 1'b0;
		end
	end

endmodule

[rtl/core/msd_emit.sv]
module msd_emit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  msd_pkg::lane_s1_t          lane_s1,
	input  logic [msd_pkg::CHAR_W-1:0] rdata,
	output logic                       advance,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [msd_pkg::CHAR_W-1:0] out_char
);

	logic has_letter, has_res, out_free;

	assign has_letter = lane_s1.boundary && !lane_s1.invalid
		&& (rdata != msd_pkg::CH_NONE) && (rdata != msd_pkg::CH_FILLER);
	assign has_res  = has_letter || lane_s1.word_space;
	assign out_free = !out_valid || out_ready;
	assign advance  = lane_s1.valid && (!has_res || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && has_res) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			out_char <= has_letter ? rdata : msd_pkg::CH_SPACE;
		end
	end

endmodule

[rtl/core/morse_symbol_decoder_core.sv]
// morse symbol decoder
// input channel s_axis: one text character per item; '.' steps to the dot
// child, '-' to the dash child of the Morse tree, ' ' ends the letter, and
// tlast ends the letter and the line. other bytes are ignored.
// output channel m_axis: one decoded character per finished letter, or a
// space for two spaces in a row; letters that left the tree, filler nodes
// and empty letters produce no item.
// throughput: one item per cycle while the output does not stall. the walk state is
// registered and the letter lookup is a single registered read of the tree memory.
// path: after its input item is accepted, a result passes the read stage, then
// the output register, before it appears on m_axis.
// reset: clears the walk to the root and drops all pending items. the tree
// memory is then loaded from the constant table, one entry a cycle, so
// s_axis_tready stays low after reset until every entry is loaded.
// stalls: the output register holds while m_axis_tready is low; one more item
// waits in the read stage, and s_axis_tready drops only once both are full.
module morse_symbol_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] symbol
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [7:0] character
);

	msd_pkg::lane_s1_t          lane_s1;
	logic                       advance;
	logic                       ram_we, ram_re;
	logic [msd_pkg::NODE_W-1:0] ram_waddr, ram_raddr;
	logic [msd_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;

	// walk state, tree load sweep and lookup address
	msd_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.symbol    (s_axis_tdata),
		.last      (s_axis_tlast),
		.advance   (advance),
		.lane_s1   (lane_s1),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	// Morse tree, heap indexed
	msd_ram #(
		.WIDTH (msd_pkg::CHAR_W),
		.DEPTH (msd_pkg::TREE_DEPTH)
	) u_tree (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// letter or word space select and output register
	msd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.lane_s1   (lane_s1),
		.rdata     (ram_rdata),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata)
	);

endmodule

[rtl/core/msd_checker.sv]
module msd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
	else $error("stalled output item changed");

	// missing and filler nodes never leave the block
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata != msd_pkg::CH_NONE)
			&& (m_axis_tdata != msd_pkg::CH_FILLER))
	else $error("filler or missing node emitted");

	// an idle output only wakes up for an accepted input item, through the read stage and the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
	else $error("output item without a matching input item");

	// an item that ends no letter gives no result
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tlast
			&& (s_axis_tdata != msd_pkg::CH_SPACE) && !m_axis_tvalid
		|=> ##1 !$rose(m_axis_tvalid))
	else $error("result from an item that ends no letter");

endmodule

bind morse_symbol_decoder_core msd_checker u_msd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

[sim/morse_symbol_decoder_core_test.sv]
module morse_symbol_decoder_core_test;

	// keeps its own copy of the Morse walk and the characters still owed by the block
	class letter_scoreboard;
		logic [7:0]                 tree [msd_pkg::TREE_DEPTH];
		logic [msd_pkg::NODE_W-1:0] node;
		bit                         off_tree;
		bit                         after_space;
		logic [7:0]                 expected_chars [$];
		int                         bad_chars;

		function new();
			string top_rows;
			top_rows = "#ETIANMSURWDKGOHVF#L#PJBXCYZQ##54";
			foreach (tree[i]) tree[i] = msd_pkg::CH_NONE;
			for (int i = 0; i < top_rows.len(); i++) tree[i] = top_rows[i];
			tree[34]  = "3";    tree[37]  = msd_pkg::CH_FILLER; tree[38]  = "2";
			tree[39]  = "&";    tree[40]  = msd_pkg::CH_FILLER; tree[41]  = "+";
			tree[44]  = msd_pkg::CH_FILLER; tree[46] = "1";     tree[47]  = "6";
			tree[48]  = "=";    tree[49]  = "/";       tree[52]  = msd_pkg::CH_FILLER;
			tree[53]  = "(";    tree[55]  = "7";       tree[56]  = msd_pkg::CH_FILLER;
			tree[58]  = 8'd165; tree[59]  = "8";       tree[61]  = "9";
			tree[62]  = "0";    tree[75]  = "?";       tree[76]  = "_";
			tree[81]  = 8'h22;  tree[84]  = ".";       tree[89]  = "@";
			tree[93]  = 8'd39;  tree[96]  = "-";       tree[105] = ";";
			tree[106] = "!";    tree[108] = ")";       tree[114] = ",";
			tree[119] = ":";
			node        = msd_pkg::ROOT_NODE;
			off_tree    = 1'b0;
			after_space = 1'b0;
			bad_chars   = 0;
		endfunction

		// walk one symbol and queue the character it finishes, if any
		function void note_symbol(logic [7:0] sym, logic lst);
			int         child;
			logic [7:0] found;
			bit         is_gap;
			bit         emitted;
			is_gap  = (sym == msd_pkg::CH_SPACE);
			emitted = 1'b0;
			if ((sym == msd_pkg::CH_DOT || sym == msd_pkg::CH_DASH) && !off_tree) begin
				if (node > msd_pkg::LAST_INNER) begin
					off_tree = 1'b1;
				end else begin
					child = 2 * node + ((sym == msd_pkg::CH_DASH) ? 2 : 1);
					if (child >= msd_pkg::TREE_DEPTH || tree[child] == msd_pkg::CH_NONE) begin
						off_tree = 1'b1;
					end else begin
						node = msd_pkg::NODE_W'(child);
					end
				end
			end
			if (is_gap || lst) begin
				if (!off_tree) begin
					found = tree[node];
					if (found != msd_pkg::CH_NONE && found != msd_pkg::CH_FILLER) begin
						expected_chars.push_back(found);
						emitted = 1'b1;
					end
				end
				node     = msd_pkg::ROOT_NODE;
				off_tree = 1'b0;
			end
			if (is_gap && after_space && !emitted) expected_chars.push_back(msd_pkg::CH_SPACE);
			after_space = is_gap && !lst;
		endfunction

		function void check_char(logic [7:0] got);
			logic [7:0] want;
			if (expected_chars.size() == 0) begin
				$display("%0t: character expected none actual %02h", $time, got);
				bad_chars++;
			end else begin
				want = expected_chars.pop_front();
				if (got !== want) begin
					$display("%0t: character expected %02h actual %02h", $time, want, got);
					bad_chars++;
				end
			end
		endfunction

		function int waiting();
			return expected_chars.size();
		endfunction
	endclass

	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_TOTAL = 950;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;

	letter_scoreboard board;
	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	bit hold_asked;

	morse_symbol_decoder_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// output check first, since a result never comes from the item accepted at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) board.check_char(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready) board.note_symbol(s_axis_tdata, s_axis_tlast);
		end
	end

	// receiver: random stalls, plus one long hold-off when asked
	initial begin
		m_axis_tready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_asked) begin
				hold_asked = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			@(negedge clk);
		end
	end

	// called and returns at a falling edge
	task automatic send_item(input logic [7:0] sym, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sym;
		s_axis_tlast  <= lst;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string txt, input bit mark_last);
		for (int i = 0; i < txt.len(); i++) send_item(txt[i], mark_last && i == txt.len() - 1);
	endtask

	// one letter of random dots and dashes with a random ending, now and then a stray byte
	task automatic send_random_letter();
		int         len;
		int         ending;
		bit         step_last;
		logic [7:0] sym;
		len       = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : 7;
		ending    = $urandom_range(9);
		step_last = (ending == 9);
		for (int i = 0; i < len; i++) begin
			sym = $urandom_range(1) ? msd_pkg::CH_DASH : msd_pkg::CH_DOT;
			if ($urandom_range(24) == 0) sym = 8'($urandom_range(255));
			send_item(sym, step_last && i == len - 1);
		end
		case (ending)
			0, 1, 2, 3, 4, 5: send_item(msd_pkg::CH_SPACE, 1'b0);
			6: begin
				send_item(msd_pkg::CH_SPACE, 1'b0);
				send_item(msd_pkg::CH_SPACE, 1'b0);
			end
			7: send_item(msd_pkg::CH_SPACE, 1'b1);
			8: send_item(8'($urandom_range(255)), 1'b1);
			default: ;
		endcase
	endtask

	// sender goes quiet until every owed character has come out
	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		while (board.waiting() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	initial begin
		board         = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		items_sent    = 0;
		hold_asked    = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: plain letter, word space, dash marked last, past depth six,
		// filler node, ignored byte marked last, boundary at the root
		send_text(". ", 1'b0);
		send_text(" ", 1'b0);
		send_text("--.--", 1'b1);
		send_text("..--.-. ", 1'b0);
		send_text("..-- ", 1'b0);
		send_item(msd_pkg::CH_DASH, 1'b0);
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(msd_pkg::CH_SPACE, 1'b0);
		wait_for_drain();

		send_idle_pct = 16;
		recv_idle_pct = 51;
		hold_asked    = 1'b1;
		while (items_sent < ITEMS_TOTAL / 3) send_random_letter();
		wait_for_drain();

		send_idle_pct = 51;
		recv_idle_pct = 16;
		while (items_sent < 2 * ITEMS_TOTAL / 3) send_random_letter();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (items_sent < ITEMS_TOTAL) send_random_letter();

		wait_for_drain();
		repeat (8) @(negedge clk);
		if (board.bad_chars == 0 && board.waiting() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#(12 * 200000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
